FILE: rtl/nwl_pkg.sv
`default_nettype none

package nwl_pkg;

  // default sizes of the path table and of one coordinate
  localparam int unsigned MAX_WAYPOINTS_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF    = 24;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LA_W     = 6;

  localparam logic [LA_W-1:0] LA_RESET = 6'd2;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_APPEND = 2'd0;
  localparam cmd_t CMD_SEAL   = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED   = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_SEALED   = 3'd2,
    ST_REJECTED = 3'd3,
    ST_ANSWERED = 3'd4
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    store;        // append pos into the table
    logic    seal;         // close the table
    logic    start_query;  // latch query position, clear best and scan address
    logic    scan_issue;   // read next waypoint and advance
    logic    tgt_issue;    // read the target waypoint
    logic    res_simple;   // result with status only
    logic    res_answer;   // result from the finished search
    status_e res_status;
    logic    out_load;     // move result into the output register
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic sealed;
    logic full;
    logic empty;
    logic scan_last;  // scan address is at the last stored waypoint
    logic pipe_busy;  // distance pipeline still holds waypoints
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/nwl_ram.sv
`default_nettype none

module nwl_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nwl_ctrl.sv
`default_nettype none

module nwl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire nwl_pkg::cmd_t     cmd_i,
  input  wire nwl_pkg::dp_stat_t dp_stat_i,
  output nwl_pkg::dp_cmd_t       dp_cmd_o
);

  import nwl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_TADDR,
    S_TDATA,
    S_PUSH
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    dp_cmd_o.res_status = ST_REJECTED;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_i)
            CMD_APPEND: begin
              dp_cmd_o.res_simple = 1'b1;
              state_d             = S_PUSH;
              if (!dp_stat_i.sealed && !dp_stat_i.full) begin
                dp_cmd_o.store      = 1'b1;
                dp_cmd_o.res_status = ST_STORED;
              end else begin
                dp_cmd_o.res_status = ST_IGNORED;
              end
            end
            CMD_SEAL: begin
              dp_cmd_o.seal       = 1'b1;
              dp_cmd_o.res_simple = 1'b1;
              dp_cmd_o.res_status = ST_SEALED;
              state_d             = S_PUSH;
            end
            default: begin
              if (cmd_i == CMD_QUERY && dp_stat_i.sealed && !dp_stat_i.empty) begin
                dp_cmd_o.start_query = 1'b1;
                state_d              = S_SCAN;
              end else begin
                dp_cmd_o.res_simple = 1'b1;
                dp_cmd_o.res_status = ST_REJECTED;
                state_d             = S_PUSH;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        dp_cmd_o.scan_issue = 1'b1;
        if (dp_stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!dp_stat_i.pipe_busy) begin
          state_d = S_TADDR;
        end
      end
      S_TADDR: begin
        dp_cmd_o.tgt_issue = 1'b1;
        state_d            = S_TDATA;
      end
      S_TDATA: begin
        dp_cmd_o.res_answer = 1'b1;
        dp_cmd_o.res_status = ST_ANSWERED;
        state_d             = S_PUSH;
      end
      S_PUSH: begin
        if (dp_stat_i.out_free) begin
          dp_cmd_o.out_load = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.out_load |-> dp_stat_i.out_free)
    else $error("result moved into a busy output register");

  a_scan_on_sealed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (dp_stat_i.sealed && !dp_stat_i.empty))
    else $error("scan running on an open or empty table");

  a_tdata_to_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TDATA) |=> (state_q == S_PUSH))
    else $error("answer not handed to output stage");

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.store |-> (!dp_stat_i.full && !dp_stat_i.sealed))
    else $error("store into full or sealed table");

endmodule

`default_nettype wire

FILE: rtl/nwl_dp.sv
`default_nettype none

module nwl_dp #(
  parameter int unsigned MAX_WAYPOINTS = nwl_pkg::MAX_WAYPOINTS_DEF,
  parameter int unsigned COORD_BITS    = nwl_pkg::COORD_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire nwl_pkg::dp_cmd_t                       dp_cmd_i,
  output nwl_pkg::dp_stat_t                           dp_stat_o,
  input  wire logic signed [COORD_BITS-1:0]           pos_x_i,
  input  wire logic signed [COORD_BITS-1:0]           pos_y_i,
  input  wire logic                                   cfg_valid_i,
  input  wire logic [nwl_pkg::LA_W-1:0]               cfg_data_i,
  input  wire logic                                   out_ready_i,
  output logic                                        out_valid_o,
  output logic [nwl_pkg::STATUS_W-1:0]                out_status_o,
  output logic [$clog2(MAX_WAYPOINTS)-1:0]            out_nearest_o,
  output logic [$clog2(MAX_WAYPOINTS)-1:0]            out_target_o,
  output logic                                        out_clamped_o,
  output logic signed [COORD_BITS:0]                  out_offset_x_o,
  output logic signed [COORD_BITS:0]                  out_offset_y_o
);

  import nwl_pkg::*;

  localparam int unsigned IW = $clog2(MAX_WAYPOINTS);
  localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);
  localparam int unsigned SW = 2 * COORD_BITS + 1;  // one square
  localparam int unsigned DW = SW + 1;              // sum of two squares
  localparam int unsigned TW = ((CW > LA_W) ? CW : LA_W) + 1;

  // table state and settings
  logic [CW-1:0]   count_q;
  logic            sealed_q;
  logic [LA_W-1:0] la_q;
  logic signed [COORD_BITS-1:0] qx_q, qy_q;

  // scan pipeline
  logic [IW-1:0] addr_q;
  logic          v1_q, v2_q, v3_q;
  logic [IW-1:0] idx1_q, idx2_q, idx3_q;
  logic signed [COORD_BITS:0] dx_q, dy_q, dx_d, dy_d;
  logic signed [2*COORD_BITS+1:0] sqx_full, sqy_full;
  logic [SW-1:0] sqx_q, sqy_q;
  logic [DW-1:0] dist_w, best_d_q;
  logic [IW-1:0] best_idx_q;
  logic          first_q;

  // target
  logic [TW-1:0] tgt_sum, tgt_last, tgt_w;
  logic          clamp_w;
  logic [IW-1:0] tgt_q;
  logic          clamp_q;

  // memory
  logic [2*COORD_BITS-1:0] rdata;
  logic [IW-1:0]           raddr;
  logic signed [COORD_BITS-1:0] rx, ry;
  logic signed [COORD_BITS:0]   ox_w, oy_w;

  // result stage
  logic [STATUS_W-1:0]        res_status_q;
  logic [IW-1:0]              res_near_q, res_tgt_q;
  logic                       res_clamp_q;
  logic signed [COORD_BITS:0] res_ox_q, res_oy_q;

  assign raddr = dp_cmd_i.tgt_issue ? tgt_w[IW-1:0] : addr_q;

  nwl_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_WAYPOINTS)
  ) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (dp_cmd_i.store),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i ({pos_y_i, pos_x_i}),
    .re_i    (dp_cmd_i.scan_issue || dp_cmd_i.tgt_issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rx = $signed(rdata[COORD_BITS-1:0]);
  assign ry = $signed(rdata[2*COORD_BITS-1:COORD_BITS]);

  assign dx_d = {qx_q[COORD_BITS-1], qx_q} - {rx[COORD_BITS-1], rx};
  assign dy_d = {qy_q[COORD_BITS-1], qy_q} - {ry[COORD_BITS-1], ry};

  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;

  assign dist_w = {1'b0, sqx_q} + {1'b0, sqy_q};

  assign tgt_sum  = TW'(best_idx_q) + TW'(la_q);
  assign tgt_last = TW'(count_q) - TW'(1);
  assign clamp_w  = tgt_sum > tgt_last;
  assign tgt_w    = clamp_w ? tgt_last : tgt_sum;

  assign ox_w = {rx[COORD_BITS-1], rx} - {qx_q[COORD_BITS-1], qx_q};
  assign oy_w = {ry[COORD_BITS-1], ry} - {qy_q[COORD_BITS-1], qy_q};

  assign dp_stat_o.sealed    = sealed_q;
  assign dp_stat_o.full      = (count_q == CW'(MAX_WAYPOINTS));
  assign dp_stat_o.empty     = (count_q == '0);
  assign dp_stat_o.scan_last = (CW'(addr_q) == (count_q - CW'(1)));
  assign dp_stat_o.pipe_busy = v1_q || v2_q || v3_q;
  assign dp_stat_o.out_free  = !out_valid_o || out_ready_i;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sealed_q    <= 1'b0;
      la_q        <= LA_RESET;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      first_q     <= 1'b0;
      addr_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        la_q <= cfg_data_i;
      end
      if (dp_cmd_i.store) begin
        count_q <= count_q + CW'(1);
      end
      if (dp_cmd_i.seal) begin
        sealed_q <= 1'b1;
      end
      v1_q <= dp_cmd_i.scan_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (dp_cmd_i.start_query) begin
        addr_q  <= '0;
        first_q <= 1'b1;
      end else begin
        if (dp_cmd_i.scan_issue) begin
          addr_q <= addr_q + IW'(1);
        end
        if (v3_q) begin
          first_q <= 1'b0;
        end
      end
      if (dp_cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.start_query) begin
      qx_q <= pos_x_i;
      qy_q <= pos_y_i;
    end
    idx1_q <= addr_q;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    sqx_q  <= sqx_full[SW-1:0];
    sqy_q  <= sqy_full[SW-1:0];
    // strict compare keeps the lowest index on ties
    if (v3_q && (first_q || dist_w < best_d_q)) begin
      best_d_q   <= dist_w;
      best_idx_q <= idx3_q;
    end
    if (dp_cmd_i.tgt_issue) begin
      tgt_q   <= tgt_w[IW-1:0];
      clamp_q <= clamp_w;
    end
    if (dp_cmd_i.res_simple) begin
      res_status_q <= dp_cmd_i.res_status;
      res_near_q   <= '0;
      res_tgt_q    <= '0;
      res_clamp_q  <= 1'b0;
      res_ox_q     <= '0;
      res_oy_q     <= '0;
    end else if (dp_cmd_i.res_answer) begin
      res_status_q <= dp_cmd_i.res_status;
      res_near_q   <= best_idx_q;
      res_tgt_q    <= tgt_q;
      res_clamp_q  <= clamp_q;
      res_ox_q     <= ox_w;
      res_oy_q     <= oy_w;
    end
    if (dp_cmd_i.out_load) begin
      out_status_o   <= res_status_q;
      out_nearest_o  <= res_near_q;
      out_target_o   <= res_tgt_q;
      out_clamped_o  <= res_clamp_q;
      out_offset_x_o <= res_ox_q;
      out_offset_y_o <= res_oy_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/nearest_waypoint_lookahead.sv
// nearest waypoint search with lookahead
//
// channels: slave stream s_axis takes one transaction per command, tuser
// carries the command (append, seal, query), tdata the x,y position.
// master stream m_axis returns exactly one result transaction per command,
// tuser the status, tdata the indices, clamp flag and target offset.
// cfg_* writes the lookahead register; it is always ready and should only
// be written while no command is in flight.
// append, seal and rejected commands pass through the result stage and the
// output register to m_axis. an answered query first reads one stored
// waypoint per cycle through the single read port of the path ram,
// then a 3-stage distance pipeline (difference, square, compare) drains,
// then one ram read for the target waypoint, then result stage and output.
// commands are handled one at a time; a new command is taken as soon as the
// previous result sits in the output register, even while m_axis stalls.
// if the receiver holds m_axis_tready low, the output register keeps its
// transaction and the next result waits in the result stage.
// reset clears the table (count zero, unsealed), sets lookahead to 2 and
// empties the output register; path ram contents are not cleared.
`default_nettype none

module nearest_waypoint_lookahead #(
  parameter int unsigned MAX_WAYPOINTS = nwl_pkg::MAX_WAYPOINTS_DEF,
  parameter int unsigned COORD_BITS    = nwl_pkg::COORD_BITS_DEF,
  localparam int unsigned IW    = $clog2(MAX_WAYPOINTS),
  localparam int unsigned IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_N = 2 * IW + 1 + 2 * (COORD_BITS + 1),
  localparam int unsigned OUT_W = ((OUT_N + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command stream
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [IN_W-1:0]               s_axis_tdata_i,   // pos_x, pos_y, zero pad
  input  wire logic [nwl_pkg::CMD_W-1:0]     s_axis_tuser_i,   // cmd
  // result stream
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [OUT_W-1:0]                   m_axis_tdata_o,   // nearest_index, target_index,
                                                               // target_clamped, offset_x,
                                                               // offset_y, zero pad
  output logic [nwl_pkg::STATUS_W-1:0]       m_axis_tuser_o,   // status
  // lookahead register write
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [nwl_pkg::LA_W-1:0]      cfg_data_i
);

  import nwl_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic signed [COORD_BITS-1:0] pos_x, pos_y;
  logic [IW-1:0]                nearest, target;
  logic                         clamped;
  logic signed [COORD_BITS:0]   off_x, off_y;

  // register write is always accepted
  assign cfg_ready_o = 1'b1;

  // unpack command payload, upper pad bits carry nothing
  assign pos_x = $signed(s_axis_tdata_i[COORD_BITS-1:0]);
  assign pos_y = $signed(s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]);

  nwl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_i      (cmd_t'(s_axis_tuser_i)),
    .dp_stat_i  (dp_stat),
    .dp_cmd_o   (dp_cmd)
  );

  nwl_dp #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dp_cmd_i       (dp_cmd),
    .dp_stat_o      (dp_stat),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_status_o   (m_axis_tuser_o),
    .out_nearest_o  (nearest),
    .out_target_o   (target),
    .out_clamped_o  (clamped),
    .out_offset_x_o (off_x),
    .out_offset_y_o (off_y)
  );

  // pack result fields from the lowest bit up, zero fill to whole bytes
  assign m_axis_tdata_o = OUT_W'({off_y, off_x, clamped, target, nearest});

endmodule

`default_nettype wire

FILE: tb/sv/nearest_waypoint_lookahead_tb.sv
`timescale 1ns / 1ps

module nearest_waypoint_lookahead_tb;
  import nwl_pkg::*;

  localparam int unsigned DEPTH = MAX_WAYPOINTS_DEF;
  localparam int unsigned CW    = COORD_BITS_DEF;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned IN_W  = ((2 * CW + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((2 * IW + 1 + 2 * (CW + 1) + 7) / 8) * 8;

  // number of waypoints loaded into the path
  localparam int unsigned PATH_LEN = 400;

  // code the block does not define, answered as a rejected query
  localparam cmd_t CMD_UNUSED = 2'd3;

  localparam int unsigned WATCHDOG_LIMIT = 8000;
  localparam int unsigned HOLDOFF_CYCLES = 120;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   offset_t;
  typedef logic [IW-1:0]        index_t;

  localparam coord_t C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW - 1){1'b0}}};

  typedef struct packed {
    status_e status;
    index_t  nearest;
    index_t  target;
    logic    clamped;
    offset_t off_x;
    offset_t off_y;
  } nav_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i;   // pos_x, pos_y
  logic [CMD_W-1:0]  s_axis_tuser_i;   // cmd
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [OUT_W-1:0]  m_axis_tdata_o;   // nearest_index, target_index, target_clamped,
                                       // offset_x, offset_y, zero pad
  logic [STATUS_W-1:0] m_axis_tuser_o; // status
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [LA_W-1:0]   cfg_data_i;

  // mirror of the path table and the lookahead register
  coord_t          mirror_x [DEPTH];
  coord_t          mirror_y [DEPTH];
  int unsigned     mirror_count;
  bit              mirror_sealed;
  logic [LA_W-1:0] mirror_lookahead;

  nav_result_t pending_answers[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          idle_en;
  bit          holdoff_req;

  nearest_waypoint_lookahead dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // steering answer for one command, updates the mirrored table
  function automatic nav_result_t compute_steering(cmd_t cmd, coord_t qx, coord_t qy);
    nav_result_t r;
    longint      dx, dy, sq_dist, best_dist;
    int unsigned best, tgt, last;
    r = '0;
    r.status = ST_REJECTED;
    if (cmd == CMD_APPEND) begin
      if (mirror_sealed || mirror_count >= DEPTH) begin
        r.status = ST_IGNORED;
      end else begin
        mirror_x[mirror_count] = qx;
        mirror_y[mirror_count] = qy;
        mirror_count++;
        r.status = ST_STORED;
      end
    end else if (cmd == CMD_SEAL) begin
      mirror_sealed = 1'b1;
      r.status = ST_SEALED;
    end else if (cmd == CMD_QUERY && mirror_sealed && mirror_count != 0) begin
      best = 0;
      best_dist = 0;
      for (int unsigned i = 0; i < mirror_count; i++) begin
        dx = longint'(qx) - longint'(mirror_x[i]);
        dy = longint'(qy) - longint'(mirror_y[i]);
        sq_dist = dx * dx + dy * dy;
        // strict compare keeps the lowest index on a tie
        if (i == 0 || sq_dist < best_dist) begin
          best = i;
          best_dist = sq_dist;
        end
      end
      last = mirror_count - 1;
      tgt = best + mirror_lookahead;
      if (tgt > last) begin
        tgt = last;
        r.clamped = 1'b1;
      end
      r.status  = ST_ANSWERED;
      r.nearest = index_t'(best);
      r.target  = index_t'(tgt);
      r.off_x   = offset_t'(longint'(mirror_x[tgt]) - longint'(qx));
      r.off_y   = offset_t'(longint'(mirror_y[tgt]) - longint'(qy));
    end
    return r;
  endfunction

  function automatic coord_t saturate(longint v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return coord_t'(v);
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  // one command transaction, with a random gap in front of it while idle_en is set
  task automatic send_command(cmd_t cmd, coord_t x, coord_t y);
    int unsigned gap;
    nav_result_t expected;
    gap = idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected = compute_steering(cmd, x, y);
    pending_answers = {pending_answers, expected};
  endtask

  // stop offering commands and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_lookahead(logic [LA_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror_lookahead = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result checker, one transaction per edge at most
  always @(posedge clk_i) begin : result_check
    nav_result_t want;
    nav_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status  = status_e'(m_axis_tuser_o);
      got.nearest = m_axis_tdata_o[IW-1:0];
      got.target  = m_axis_tdata_o[2*IW-1:IW];
      got.clamped = m_axis_tdata_o[2*IW];
      got.off_x   = m_axis_tdata_o[2*IW+1 +: CW+1];
      got.off_y   = m_axis_tdata_o[2*IW+CW+2 +: CW+1];
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, m_axis_tuser_o);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        check_field("status", want.status, got.status);
        check_field("nearest_index", want.nearest, got.nearest);
        check_field("target_index", want.target, got.target);
        check_field("target_clamped", want.clamped, got.clamped);
        check_field("offset_x", longint'($signed(want.off_x)), longint'($signed(got.off_x)));
        check_field("offset_y", longint'($signed(want.off_y)), longint'($signed(got.off_y)));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result receiver: random stalls per transaction while idle_en is set, plus a long hold-off on request
  initial begin : result_sink
    int unsigned low;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      low = idle_en ? $urandom_range(0, 4) : 0;
      if (holdoff_req) begin
        low += HOLDOFF_CYCLES;
        holdoff_req = 1'b0;
      end
      if (low > 0) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
        repeat (low - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // queries and odd codes against an empty, open table
  task automatic test_before_seal();
    write_lookahead(6'd63);
    send_command(CMD_QUERY, '0, '0);
    send_command(CMD_QUERY, C_MAX, C_MIN);
    send_command(CMD_UNUSED, C_MIN, C_MAX);
    send_command(CMD_UNUSED, any_coord(), any_coord());
  endtask

  // load the path: corners and a tie pair first, then a random walk with jumps, repeats and some query and unused codes
  task automatic test_load_path();
    longint      wx, wy;
    int unsigned pick, k, n;
    send_command(CMD_APPEND, C_MAX, C_MAX);
    send_command(CMD_APPEND, C_MIN, C_MIN);
    send_command(CMD_APPEND, C_MIN, C_MAX);
    send_command(CMD_APPEND, C_MAX, C_MIN);
    send_command(CMD_APPEND, '0, '0);
    send_command(CMD_APPEND, '0, '0);
    wx = longint'(any_coord());
    wy = longint'(any_coord());
    n = 0;
    while (mirror_count < PATH_LEN) begin
      // back-to-back stretch; the receiver holds off once so the block backs up
      if (n == 250) begin
        idle_en = 1'b0;
        holdoff_req = 1'b1;
      end
      if (n == 340) idle_en = 1'b1;
      n++;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_command(CMD_QUERY, any_coord(), any_coord());
      end else if (pick < 6) begin
        send_command(CMD_UNUSED, any_coord(), any_coord());
      end else if (pick < 10) begin
        // repeat an earlier waypoint to make distance ties
        k = $urandom_range(0, mirror_count - 1);
        send_command(CMD_APPEND, mirror_x[k], mirror_y[k]);
      end else begin
        if (pick < 14) begin
          wx = longint'(any_coord());
          wy = longint'(any_coord());
        end else begin
          wx = longint'(saturate(wx + longint'($urandom_range(0, 8000)) - 4000));
          wy = longint'(saturate(wy + longint'($urandom_range(0, 8000)) - 4000));
        end
        send_command(CMD_APPEND, coord_t'(wx), coord_t'(wy));
      end
    end
  endtask

  task automatic test_seal();
    send_command(CMD_SEAL, any_coord(), any_coord());
    send_command(CMD_SEAL, '0, '0);
    send_command(CMD_APPEND, C_MAX, C_MAX);
    send_command(CMD_UNUSED, '0, '0);
  endtask

  // corners give the widest offsets, the tail of the path gives the clamp
  task automatic test_lookahead_edges();
    write_lookahead(6'd0);
    send_command(CMD_QUERY, C_MAX, C_MAX);
    send_command(CMD_QUERY, C_MIN, C_MIN);
    send_command(CMD_QUERY, '0, '0);
    send_command(CMD_QUERY, mirror_x[mirror_count-1], mirror_y[mirror_count-1]);
    write_lookahead(6'd1);
    send_command(CMD_QUERY, C_MAX, C_MAX);
    send_command(CMD_QUERY, C_MIN, C_MIN);
    send_command(CMD_QUERY, C_MIN, C_MAX);
    write_lookahead(6'd63);
    send_command(CMD_QUERY, mirror_x[mirror_count-64], mirror_y[mirror_count-64]);
    send_command(CMD_QUERY, mirror_x[mirror_count-63], mirror_y[mirror_count-63]);
    send_command(CMD_QUERY, mirror_x[mirror_count-1], mirror_y[mirror_count-1]);
    send_command(CMD_QUERY, C_MIN, '0);
  endtask

  // mostly queries, near the path or anywhere, and some noise commands
  task automatic test_random_traffic(logic [LA_W-1:0] la, bit idle, int unsigned count);
    int unsigned pick, k;
    coord_t      qx, qy;
    write_lookahead(la);
    idle_en = idle;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, mirror_count - 1);
      qx = any_coord();
      qy = any_coord();
      if (pick < 35) begin
        qx = saturate(longint'(mirror_x[k]) + longint'($urandom_range(0, 8190)) - 4095);
        qy = saturate(longint'(mirror_y[k]) + longint'($urandom_range(0, 8190)) - 4095);
        send_command(CMD_QUERY, qx, qy);
      end else if (pick < 55) begin
        send_command(CMD_QUERY, mirror_x[k], mirror_y[k]);
      end else if (pick < 80) begin
        send_command(CMD_QUERY, qx, qy);
      end else if (pick < 88) begin
        qx = $urandom_range(0, 1) ? C_MAX : C_MIN;
        qy = $urandom_range(0, 1) ? C_MAX : C_MIN;
        send_command(CMD_QUERY, qx, qy);
      end else if (pick < 92) begin
        send_command(CMD_APPEND, qx, qy);
      end else if (pick < 95) begin
        send_command(CMD_SEAL, qx, qy);
      end else begin
        send_command(CMD_UNUSED, qx, qy);
      end
    end
  endtask

  initial begin : run_tests
    rst_ni           = 1'b0;
    s_axis_tvalid_i  = 1'b0;
    s_axis_tdata_i   = '0;
    s_axis_tuser_i   = CMD_APPEND;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    mismatches       = 0;
    quiet_cycles     = 0;
    idle_en          = 1'b1;
    holdoff_req      = 1'b0;
    mirror_count     = 0;
    mirror_sealed    = 1'b0;
    mirror_lookahead = LA_RESET;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_before_seal();
    test_load_path();
    test_seal();
    test_lookahead_edges();
    test_random_traffic(LA_RESET, 1'b1, 25);
    test_random_traffic(6'd63, 1'b1, 25);
    test_random_traffic(6'($urandom), 1'b0, 25);
    test_random_traffic(6'd0, 1'b1, 25);
    test_random_traffic(6'($urandom), 1'b1, 25);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
